### rtl/core/dual_capture_period_timer_assert.svh
// Assertion macros shared by the dual capture period timer RTL.
`ifndef DUAL_CAPTURE_PERIOD_TIMER_ASSERT_SVH
`define DUAL_CAPTURE_PERIOD_TIMER_ASSERT_SVH

// Check that a condition holds at every clock edge out of reset.
`define DCPT_ASSERT_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition in a cycle implies another in the next cycle.
`define DCPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/dcpt_pkg.sv
// Types and constants shared by the dual capture period timer.
package dcpt_pkg;

  // Operation codes carried in the input tuser.
  localparam logic [2:0] OP_CAPTURE  = 3'd0;
  localparam logic [2:0] OP_OVERFLOW = 3'd1;
  localparam logic [2:0] OP_TICK     = 3'd2;
  localparam logic [2:0] OP_ACK      = 3'd3;
  localparam logic [2:0] OP_RX_LOAD  = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_TIMEOUT_CHAN0   = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT_CHAN1   = 2'd1;
  localparam logic [1:0] CFG_SECOND_RELOAD   = 2'd2;
  localparam logic [1:0] CFG_WATCHDOG_RELOAD = 2'd3;

  // Reset values of the divider reloads.
  localparam logic [15:0] SECOND_RELOAD_RST   = 16'd976;
  localparam logic [15:0] WATCHDOG_RELOAD_RST = 16'd100;

  // Per-channel command decoded from one accepted beat.
  typedef struct packed {
    logic        capture;
    logic        overflow;
    logic        tick;
    logic        ack;
    logic        ovf_pending;
    logic [15:0] capture_low;
    logic [15:0] timeout;
  } chan_cmd_t;

  // Per-channel state after the beat has been applied.
  typedef struct packed {
    logic        armed;
    logic        done;
    logic [31:0] first_stamp;
    logic [31:0] second_stamp;
    logic [15:0] count;
    logic        timed_out;
  } chan_stat_t;

  // Result beat, result_channel in the lowest bit.
  typedef struct packed {
    logic        watchdog_pulse;
    logic        second_pulse;
    logic        receive_timed_out;
    logic [1:0]  measure_timed_out;
    logic [15:0] capture_count;
    logic [31:0] end_stamp;
    logic [31:0] start_stamp;
    logic        period_done;
    logic        result_channel;
  } res_t;

endpackage

### rtl/core/dcpt_chan.sv
// One period-capture channel: overflow extension, stamps, phase and timeout.
module dcpt_chan #(
  parameter int TIMER_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dcpt_pkg::chan_cmd_t  cmd,
  output dcpt_pkg::chan_stat_t stat
);
  import dcpt_pkg::*;

  localparam logic [63:0] LOW_MASK = (64'd1 << TIMER_BITS) - 64'd1;

  logic [15:0] high_r, high_nxt;
  logic        armed_r, armed_nxt;
  logic        done_r, done_nxt;
  logic [31:0] first_r, first_nxt;
  logic [31:0] second_r, second_nxt;
  logic [15:0] timer_r, timer_nxt;
  logic [15:0] count_r, count_nxt;
  logic        timed_out;
  logic [63:0] stamp_wide;
  logic [31:0] stamp;
  logic [15:0] timer_dec;

  // Extend the capture with the overflow count
  assign stamp_wide = ({48'd0, high_r} << TIMER_BITS) | ({48'd0, cmd.capture_low} & LOW_MASK);
  assign stamp      = stamp_wide[31:0];
  assign timer_dec  = timer_r - 16'd1;

  // Apply the beat to the channel state
  always_comb begin
    high_nxt   = high_r;
    armed_nxt  = armed_r;
    done_nxt   = done_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    timer_nxt  = timer_r;
    count_nxt  = count_r;
    timed_out  = 1'b0;
    if (cmd.capture) begin
      count_nxt = count_r + 16'd1;
      if (cmd.ovf_pending) begin
        armed_nxt = 1'b0;
      end else if (!done_r) begin
        if (armed_r) begin
          done_nxt   = 1'b1;
          second_nxt = stamp;
          armed_nxt  = 1'b0;
        end else begin
          first_nxt = stamp;
          armed_nxt = 1'b1;
          timer_nxt = cmd.timeout;
        end
      end
    end
    if (cmd.overflow) begin
      high_nxt = high_r + 16'd1;
    end
    if (cmd.tick && timer_r != 16'd0) begin
      timer_nxt = timer_dec;
      if (timer_dec == 16'd0) begin
        armed_nxt = 1'b0;
        timed_out = 1'b1;
      end
    end
    if (cmd.ack) begin
      done_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_r   <= '0;
      armed_r  <= 1'b0;
      done_r   <= 1'b0;
      first_r  <= '0;
      second_r <= '0;
      timer_r  <= '0;
      count_r  <= '0;
    end else begin
      high_r   <= high_nxt;
      armed_r  <= armed_nxt;
      done_r   <= done_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
      timer_r  <= timer_nxt;
      count_r  <= count_nxt;
    end
  end

  // Report the state as it stands after this beat
  assign stat.armed        = armed_nxt;
  assign stat.done         = done_nxt;
  assign stat.first_stamp  = first_nxt;
  assign stat.second_stamp = second_nxt;
  assign stat.count        = count_nxt;
  assign stat.timed_out    = timed_out;

endmodule

### rtl/core/dual_capture_period_timer.sv
// Top level of the dual capture period timer.
//
// Usage: each input beat on in_* carries one operation in in_tuser (capture,
// counter overflow, tick, acknowledge, load receive timeout) and yields exactly
// one result beat on out_*, reporting the addressed channel's done flag,
// 32-bit start and end stamps and capture count, plus the tick pulses
// (measurement timeouts, receive timeout, seconds and watchdog dividers).
// Ticks, receive loads and unused operation codes report channel zero.
// The result is registered: it appears in the output register the cycle after
// the input beat is taken. Throughput is one beat per cycle while the output
// is not stalled; all state updates finish in the accept cycle, so the output
// register sets the rate. When the receiver stalls, the result holds in the
// output register and in_tready drops until it is taken; it rises again in
// the cycle the result leaves. Configuration writes on cfg_* are always taken
// and belong in idle periods; divider reload changes apply at the next expiry.
// Reset clears the channels, the receive timer and the output valid, sets
// the reloads to 976 and 100 and loads the dividers with them.
`include "dual_capture_period_timer_assert.svh"

module dual_capture_period_timer #(
  parameter int TIMER_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: channel, capture_low[15:0], overflow_pending,
  //           receive_timeout_load[15:0], zero fill
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,
  // in_tuser: operation[2:0]
  input  logic [2:0]  in_tuser,
  // out_tdata: result_channel, period_done, start_stamp[31:0], end_stamp[31:0],
  //            capture_count[15:0], measure_timed_out[1:0], receive_timed_out,
  //            second_pulse, watchdog_pulse, zero fill
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import dcpt_pkg::*;

  logic        in_fire;
  logic [2:0]  op;
  logic        chan;
  logic [15:0] cap_low;
  logic        ovf_pending;
  logic [15:0] rx_load;

  logic [15:0] timeout0_r, timeout1_r, sec_reload_r, wdt_reload_r;
  logic [15:0] rx_timer_r, rx_timer_nxt;
  logic [15:0] sec_div_r, sec_div_nxt;
  logic [15:0] wdt_div_r, wdt_div_nxt;
  logic [15:0] rx_dec, sec_dec, wdt_dec;
  logic        rx_pulse, sec_pulse, wdt_pulse;
  logic        is_tick;
  logic        rep;

  chan_cmd_t   cmd [2];
  chan_stat_t  st  [2];

  logic        out_valid_r, out_valid_nxt;
  res_t        res_r, res_nxt;

  // Unpack the input beat
  assign op          = in_tuser;
  assign chan        = in_tdata[0];
  assign cap_low     = in_tdata[16:1];
  assign ovf_pending = in_tdata[17];
  assign rx_load     = in_tdata[33:18];

  // Take a beat whenever the output register is free or draining
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign is_tick   = in_fire && (op == OP_TICK);

  // Hold configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout0_r   <= '0;
      timeout1_r   <= '0;
      sec_reload_r <= SECOND_RELOAD_RST;
      wdt_reload_r <= WATCHDOG_RELOAD_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TIMEOUT_CHAN0:   timeout0_r   <= cfg_data;
        CFG_TIMEOUT_CHAN1:   timeout1_r   <= cfg_data;
        CFG_SECOND_RELOAD:   sec_reload_r <= cfg_data;
        CFG_WATCHDOG_RELOAD: wdt_reload_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Decode per-channel commands
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      cmd[i].capture     = in_fire && (op == OP_CAPTURE) && (chan == i[0]);
      cmd[i].overflow    = in_fire && (op == OP_OVERFLOW) && (chan == i[0]);
      cmd[i].ack         = in_fire && (op == OP_ACK) && (chan == i[0]);
      cmd[i].tick        = is_tick;
      cmd[i].ovf_pending = ovf_pending;
      cmd[i].capture_low = cap_low;
    end
    cmd[0].timeout = timeout0_r;
    cmd[1].timeout = timeout1_r;
  end

  dcpt_chan #(.TIMER_BITS(TIMER_BITS)) u_chan0 (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (cmd[0]),
    .stat (st[0])
  );

  dcpt_chan #(.TIMER_BITS(TIMER_BITS)) u_chan1 (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (cmd[1]),
    .stat (st[1])
  );

  // Advance the receive timer and the two dividers
  assign rx_dec  = rx_timer_r - 16'd1;
  assign sec_dec = sec_div_r - 16'd1;
  assign wdt_dec = wdt_div_r - 16'd1;

  always_comb begin
    rx_timer_nxt = rx_timer_r;
    sec_div_nxt  = sec_div_r;
    wdt_div_nxt  = wdt_div_r;
    rx_pulse     = 1'b0;
    sec_pulse    = 1'b0;
    wdt_pulse    = 1'b0;
    if (in_fire && op == OP_RX_LOAD) begin
      rx_timer_nxt = rx_load;
    end
    if (is_tick) begin
      if (rx_timer_r != 16'd0) begin
        rx_timer_nxt = rx_dec;
        rx_pulse     = (rx_dec == 16'd0);
      end
      sec_div_nxt = sec_dec;
      if (sec_dec == 16'd0) begin
        sec_div_nxt = sec_reload_r;
        sec_pulse   = 1'b1;
      end
      wdt_div_nxt = wdt_dec;
      if (wdt_dec == 16'd0) begin
        wdt_div_nxt = wdt_reload_r;
        wdt_pulse   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_timer_r <= '0;
      sec_div_r  <= SECOND_RELOAD_RST;
      wdt_div_r  <= WATCHDOG_RELOAD_RST;
    end else begin
      rx_timer_r <= rx_timer_nxt;
      sec_div_r  <= sec_div_nxt;
      wdt_div_r  <= wdt_div_nxt;
    end
  end

  // Build the result beat for the reported channel
  assign rep = (op == OP_CAPTURE || op == OP_OVERFLOW || op == OP_ACK) ? chan : 1'b0;

  always_comb begin
    res_nxt.result_channel       = rep;
    res_nxt.period_done          = st[rep].done;
    res_nxt.start_stamp          = st[rep].first_stamp;
    res_nxt.end_stamp            = st[rep].second_stamp;
    res_nxt.capture_count        = st[rep].count;
    res_nxt.measure_timed_out[0] = st[0].timed_out;
    res_nxt.measure_timed_out[1] = st[1].timed_out;
    res_nxt.receive_timed_out    = rx_pulse;
    res_nxt.second_pulse         = sec_pulse;
    res_nxt.watchdog_pulse       = wdt_pulse;
  end

  // Hold the result until the receiver takes it
  assign out_valid_nxt = in_fire || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, res_r};

  // A channel is never armed while its period is done
  `DCPT_ASSERT_HOLDS(a_armed_done_excl,
    !(st[0].armed && st[0].done) && !(st[1].armed && st[1].done),
    "channel armed while done")
  // Only a tick raises a pulse
  `DCPT_ASSERT_NEXT(a_pulse_tick_only, in_fire && op != OP_TICK,
    res_r.measure_timed_out == 2'b00 && !res_r.receive_timed_out &&
    !res_r.second_pulse && !res_r.watchdog_pulse, "pulse outside tick")
  // A tick with one receive tick left reports the timeout
  `DCPT_ASSERT_NEXT(a_rx_expiry, is_tick && rx_timer_r == 16'd1,
    res_r.receive_timed_out && rx_timer_r == 16'd0, "receive timeout missed")
  // A stalled result stays put
  `DCPT_ASSERT_NEXT(a_result_hold, out_valid_r && !out_tready,
    out_valid_r && $stable(res_r), "stalled result changed")

endmodule

### tb/sv/dual_capture_period_timer_test.sv
// Self-checking stream testbench for the dual capture period timer.
module dual_capture_period_timer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dcpt_pkg::*;

  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int RAND_ITEMS  = 250;
  localparam int NUM_PHASES  = 5;

  // One input beat, split into its fields.
  typedef struct packed {
    logic [2:0]  op;
    logic        ch;
    logic [15:0] low;
    logic        ovf;
    logic [15:0] rxl;
  } beat_t;

  // One row of the directed stimulus table.
  typedef struct packed {
    beat_t b;
    logic  typed;
    res_t  want;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [87:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  // Register settings per phase: timeout 0, timeout 1, second reload, watchdog reload.
  logic [15:0] phase_regs [NUM_PHASES][4] = '{
    '{16'd3,     16'd5,     16'd1,     16'd1},
    '{16'd65535, 16'd0,     16'd3,     16'd2},
    '{16'd0,     16'd65535, 16'd0,     16'd65535},
    '{16'd12,    16'd25,    16'd7,     16'd13},
    '{16'd1,     16'd2,     16'd65535, 16'd4}
  };

  // Shadow of the configuration registers.
  logic [15:0] tmo_cfg [2];
  logic [15:0] sec_reload;
  logic [15:0] wdt_reload;

  // Predicted channel and timebase state.
  logic [15:0] hi_cnt [2];
  logic        armed [2];
  logic        done_q [2];
  logic [31:0] start_st [2];
  logic [31:0] end_st [2];
  logic [15:0] meas_left [2];
  logic [15:0] cap_cnt [2];
  logic [15:0] rx_left;
  logic [15:0] sec_div;
  logic [15:0] wdt_div;

  res_t pending_reports [$];
  row_t dir_rows [$];
  int   fail_cnt    = 0;
  int   idle_cycles = 0;
  bit   hold_req    = 1'b0;
  bit   hold_done   = 1'b0;
  int   tx_calm     = 0;
  int   rx_calm     = 0;

  dual_capture_period_timer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Count one divider down; on reaching zero reload it and flag the pulse.
  function automatic logic [16:0] div_next(input logic [15:0] cnt, input logic [15:0] reload);
    logic [15:0] d;
    d = cnt - 16'd1;
    if (d == 16'd0) return {1'b1, reload};
    return {1'b0, d};
  endfunction

  // Apply one accepted beat to the predicted state and return the report it causes.
  function automatic res_t apply_beat(input beat_t b);
    res_t        r;
    logic        rep;
    logic [16:0] dn;
    r = '0;
    rep = 1'b0;
    case (b.op)
      OP_CAPTURE: begin
        rep = b.ch;
        if (b.ovf) begin
          armed[b.ch] = 1'b0;
        end else if (!done_q[b.ch]) begin
          if (armed[b.ch]) begin
            done_q[b.ch] = 1'b1;
            end_st[b.ch] = {hi_cnt[b.ch], b.low};
            armed[b.ch] = 1'b0;
          end else begin
            start_st[b.ch] = {hi_cnt[b.ch], b.low};
            armed[b.ch] = 1'b1;
            meas_left[b.ch] = tmo_cfg[b.ch];
          end
        end
        cap_cnt[b.ch] = cap_cnt[b.ch] + 16'd1;
      end
      OP_OVERFLOW: begin
        rep = b.ch;
        hi_cnt[b.ch] = hi_cnt[b.ch] + 16'd1;
      end
      OP_TICK: begin
        if (rx_left != 16'd0) begin
          rx_left = rx_left - 16'd1;
          if (rx_left == 16'd0) r.receive_timed_out = 1'b1;
        end
        dn = div_next(sec_div, sec_reload);
        r.second_pulse = dn[16];
        sec_div = dn[15:0];
        dn = div_next(wdt_div, wdt_reload);
        r.watchdog_pulse = dn[16];
        wdt_div = dn[15:0];
        for (int i = 0; i < 2; i++) begin
          if (meas_left[i] != 16'd0) begin
            meas_left[i] = meas_left[i] - 16'd1;
            if (meas_left[i] == 16'd0) begin
              armed[i] = 1'b0;
              r.measure_timed_out[i] = 1'b1;
            end
          end
        end
      end
      OP_ACK: begin
        rep = b.ch;
        done_q[b.ch] = 1'b0;
      end
      OP_RX_LOAD: begin
        rx_left = b.rxl;
      end
      default: begin
      end
    endcase
    r.result_channel = rep;
    r.period_done    = done_q[rep];
    r.start_stamp    = start_st[rep];
    r.end_stamp      = end_st[rep];
    r.capture_count  = cap_cnt[rep];
    return r;
  endfunction

  // Build a report with all tick pulses low.
  function automatic res_t status(input logic ch, input logic dn, input logic [31:0] s,
                                  input logic [31:0] e, input logic [15:0] c);
    res_t r;
    r = '0;
    r.result_channel = ch;
    r.period_done    = dn;
    r.start_stamp    = s;
    r.end_stamp      = e;
    r.capture_count  = c;
    return r;
  endfunction

  function automatic void add_row(input logic [2:0] op, input logic ch, input logic [15:0] low,
                                  input logic ovf, input logic [15:0] rxl, input logic typed,
                                  input res_t want);
    row_t r;
    r.b = '{op: op, ch: ch, low: low, ovf: ovf, rxl: rxl};
    r.typed = typed;
    r.want = want;
    dir_rows.push_back(r);
  endfunction

  // Mostly short gaps, a few long ones, and now and then a calm stretch.
  function automatic int pick_gap(inout int calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if (r < 3) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Random beat, weighted toward capture sequences and ticks.
  function automatic beat_t rand_beat();
    beat_t b;
    int    r;
    r = $urandom_range(0, 99);
    if (r < 38)      b.op = OP_CAPTURE;
    else if (r < 66) b.op = OP_TICK;
    else if (r < 76) b.op = OP_ACK;
    else if (r < 84) b.op = OP_OVERFLOW;
    else if (r < 94) b.op = OP_RX_LOAD;
    else             b.op = 3'($urandom_range(5, 7));
    b.ch  = 1'($urandom_range(0, 1));
    b.low = 16'($urandom);
    b.ovf = ($urandom_range(0, 7) == 0);
    if ($urandom_range(0, 3) == 0) b.rxl = 16'($urandom);
    else                           b.rxl = 16'($urandom_range(0, 12));
    return b;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      fail_cnt++;
    end
  endfunction

  // Offer one beat after a random gap; predict its report once it is taken.
  task automatic offer(input beat_t b, input logic typed, input res_t want);
    int   g;
    res_t pred;
    g = pick_gap(tx_calm);
    if (hold_req && !hold_done) g = 0;
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= b.op;
    in_tdata  <= {6'd0, b.rxl, b.ovf, b.low, b.ch};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pred = apply_beat(b);
    pending_reports.push_back(typed ? want : pred);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_TIMEOUT_CHAN0:   tmo_cfg[0] = val;
      CFG_TIMEOUT_CHAN1:   tmo_cfg[1] = val;
      CFG_SECOND_RELOAD:   sec_reload = val;
      CFG_WATCHDOG_RELOAD: wdt_reload = val;
      default: begin
      end
    endcase
  endtask

  // Drop valid and wait until every report is back and the block is quiet.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Compare each result beat with the oldest prediction.
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = res_t'(out_tdata[86:0]);
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %h", $time, got);
        fail_cnt++;
      end else begin
        want = pending_reports.pop_front();
        check_field("result_channel", 32'(want.result_channel), 32'(got.result_channel));
        check_field("period_done", 32'(want.period_done), 32'(got.period_done));
        check_field("start_stamp", want.start_stamp, got.start_stamp);
        check_field("end_stamp", want.end_stamp, got.end_stamp);
        check_field("capture_count", 32'(want.capture_count), 32'(got.capture_count));
        check_field("measure_timed_out", 32'(want.measure_timed_out),
                    32'(got.measure_timed_out));
        check_field("receive_timed_out", 32'(want.receive_timed_out),
                    32'(got.receive_timed_out));
        check_field("second_pulse", 32'(want.second_pulse), 32'(got.second_pulse));
        check_field("watchdog_pulse", 32'(want.watchdog_pulse), 32'(got.watchdog_pulse));
      end
    end
  end

  // End the run when no beat moves on any channel for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: random ready pattern, with one long hold-off on request.
  initial begin
    int g;
    out_tready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      g = pick_gap(rx_calm);
      if (g > 0) begin
        out_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  end

  // Stimulus: reset, directed table, random phases.
  initial begin
    beat_t b;
    tmo_cfg[0]  = '0;
    tmo_cfg[1]  = '0;
    sec_reload  = SECOND_RELOAD_RST;
    wdt_reload  = WATCHDOG_RELOAD_RST;
    for (int i = 0; i < 2; i++) begin
      hi_cnt[i]    = '0;
      armed[i]     = 1'b0;
      done_q[i]    = 1'b0;
      start_st[i]  = '0;
      end_st[i]    = '0;
      meas_left[i] = '0;
      cap_cnt[i]   = '0;
    end
    rx_left = '0;
    sec_div = SECOND_RELOAD_RST;
    wdt_div = WATCHDOG_RELOAD_RST;

    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Unknown codes and the first tick after reset report all zeros; ack reports channel one, all else zero.
    add_row(3'd5, 1'b1, 16'hFFFF, 1'b1, 16'hFFFF, 1'b1, status(1'b0, 1'b0, '0, '0, '0));
    add_row(3'd7, 1'b0, 16'h0000, 1'b0, 16'h0000, 1'b1, status(1'b0, 1'b0, '0, '0, '0));
    add_row(3'd6, 1'b1, 16'h5A5A, 1'b1, 16'hA5A5, 1'b0, '0);
    add_row(OP_ACK, 1'b1, 16'h0000, 1'b0, 16'h0000, 1'b1, status(1'b1, 1'b0, '0, '0, '0));
    add_row(OP_TICK, 1'b1, 16'hFFFF, 1'b1, 16'hFFFF, 1'b1, status(1'b0, 1'b0, '0, '0, '0));
    // Start and end stamps at the extremes of the low half.
    add_row(OP_CAPTURE, 1'b0, 16'hFFFF, 1'b0, 16'h0000, 1'b1,
            status(1'b0, 1'b0, 32'h0000FFFF, '0, 16'd1));
    add_row(OP_CAPTURE, 1'b0, 16'h0000, 1'b0, 16'h0000, 1'b1,
            status(1'b0, 1'b1, 32'h0000FFFF, '0, 16'd2));
    // Capture while done only counts; then acknowledge.
    add_row(OP_CAPTURE, 1'b0, 16'h1234, 1'b0, 16'h0000, 1'b0, '0);
    add_row(OP_ACK, 1'b0, 16'h0000, 1'b0, 16'h0000, 1'b0, '0);
    // Overflows feed the high half of the stamp.
    add_row(OP_OVERFLOW, 1'b1, 16'h0000, 1'b0, 16'h0000, 1'b0, '0);
    add_row(OP_OVERFLOW, 1'b1, 16'hFFFF, 1'b1, 16'hFFFF, 1'b0, '0);
    add_row(OP_CAPTURE, 1'b1, 16'hABCD, 1'b0, 16'h0000, 1'b0, '0);
    // Overflow pending at capture disarms the phase.
    add_row(OP_CAPTURE, 1'b1, 16'h7777, 1'b1, 16'h0000, 1'b0, '0);
    add_row(OP_CAPTURE, 1'b1, 16'h0001, 1'b0, 16'h0000, 1'b0, '0);
    add_row(OP_CAPTURE, 1'b1, 16'hFFFF, 1'b0, 16'h0000, 1'b0, '0);
    // Receive timeout: load extremes, expire, then tick with the timer at zero.
    add_row(OP_RX_LOAD, 1'b0, 16'h0000, 1'b0, 16'hFFFF, 1'b0, '0);
    add_row(OP_RX_LOAD, 1'b1, 16'h0000, 1'b0, 16'h0001, 1'b0, '0);
    add_row(OP_TICK, 1'b0, 16'h0000, 1'b0, 16'h0000, 1'b0, '0);
    add_row(OP_TICK, 1'b0, 16'h0000, 1'b0, 16'h0000, 1'b0, '0);
    add_row(OP_RX_LOAD, 1'b0, 16'h0000, 1'b0, 16'h0000, 1'b0, '0);
    add_row(OP_TICK, 1'b1, 16'h0000, 1'b0, 16'h0000, 1'b0, '0);
    add_row(OP_CAPTURE, 1'b0, 16'h0000, 1'b1, 16'h0000, 1'b0, '0);
    add_row(OP_ACK, 1'b1, 16'hFFFF, 1'b1, 16'hFFFF, 1'b0, '0);

    foreach (dir_rows[i]) offer(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].want);

    // Random phases, each under its own register setting.
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      write_reg(CFG_TIMEOUT_CHAN0, phase_regs[p][0]);
      write_reg(CFG_TIMEOUT_CHAN1, phase_regs[p][1]);
      write_reg(CFG_SECOND_RELOAD, phase_regs[p][2]);
      write_reg(CFG_WATCHDOG_RELOAD, phase_regs[p][3]);
      cfg_valid <= 1'b0;
      @(posedge clk);
      if (p == 1) hold_req = 1'b1;
      for (int n = 0; n < RAND_ITEMS; n++) begin
        b = rand_beat();
        offer(b, 1'b0, '0);
      end
    end

    drain();
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
